### design/temporal_ema_ycbcr_filter_unit_defines.svh
// Assertion macros of the temporal EMA filter, used by the EMA core.
`ifndef TEMPORAL_EMA_YCBCR_FILTER_UNIT_DEFINES_SVH
`define TEMPORAL_EMA_YCBCR_FILTER_UNIT_DEFINES_SVH

// Condition that must hold in every cycle out of reset
`define TEFU_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define TEFU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TEFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/tefu_pkg.sv
// Package: shared types and constants of the temporal EMA YCbCr filter.
package tefu_pkg;

  // Default sizing
  localparam int PIXELS_DEF        = 1048576;
  localparam int FRACTION_BITS_DEF = 16;

  // Field widths
  localparam int PIX_IDX_W = 20;
  localparam int SAMPLE_W  = 8;
  localparam int FACTOR_W  = 10;

  // Configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_LSB = 2;

  // Register index (one bit of paddr above the byte lanes)
  localparam logic REG_SMOOTHING_FACTOR = 1'b0;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);

  // One pixel's samples
  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] cb;
    logic [SAMPLE_W-1:0] cr;
  } pix_t;

endpackage

### design/tefu_if.sv
// Interfaces: pixel request channel and filtered result channel.
interface tefu_pix_if import tefu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_IDX_W-1:0] pixel_index;
  logic [SAMPLE_W-1:0]  luma_in;
  logic [SAMPLE_W-1:0]  cb_in;
  logic [SAMPLE_W-1:0]  cr_in;

  modport source (output valid, pixel_index, luma_in, cb_in, cr_in, input ready);
  modport sink   (input valid, pixel_index, luma_in, cb_in, cr_in, output ready);
endinterface

interface tefu_res_if import tefu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma_out;
  logic [SAMPLE_W-1:0] cb_out;
  logic [SAMPLE_W-1:0] cr_out;

  modport source (output valid, luma_out, cb_out, cr_out, input ready);
  modport sink   (input valid, luma_out, cb_out, cr_out, output ready);
endinterface

### design/tefu_recip.sv
// Sequential reciprocal unit: weight = (2^F + N/2) / N, one quotient bit per cycle.
module tefu_recip import tefu_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [FACTOR_W-1:0]      factor,
  output logic                     busy,
  output logic [FRACTION_BITS:0]   weight
);

  localparam int DVD_W = FRACTION_BITS + 2;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [FACTOR_W-1:0] nz;
  logic [FACTOR_W-1:0] divisor;
  logic [FACTOR_W-1:0] rem;
  logic [FACTOR_W-1:0] rem_next;
  logic [FACTOR_W:0]   rem_sh;
  logic [DVD_W-1:0]    dividend;
  logic [DVD_W-1:0]    quo;
  logic [DVD_W-1:0]    quo_next;
  logic [CNT_W-1:0]    cnt;
  logic                ge;

  // zero factor acts as one
  assign nz = (factor == '0) ? FACTOR_W'(1) : factor;

  // restoring division step
  always_comb begin
    rem_sh   = {rem, dividend[DVD_W-1]};
    ge       = (rem_sh >= {1'b0, divisor});
    rem_next = ge ? FACTOR_W'(rem_sh - {1'b0, divisor}) : rem_sh[FACTOR_W-1:0];
    quo_next = {quo[DVD_W-2:0], ge};
  end

  // control and result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      weight <= {1'b1, {FRACTION_BITS{1'b0}}};
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy   <= 1'b0;
        weight <= quo_next[FRACTION_BITS:0];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      divisor  <= nz;
      dividend <= (DVD_W'(1) << FRACTION_BITS) + DVD_W'(nz[FACTOR_W-1:1]);
      rem      <= '0;
      quo      <= '0;
    end else if (busy) begin
      divisor  <= divisor;
      dividend <= {dividend[DVD_W-2:0], 1'b0};
      rem      <= rem_next;
      quo      <= quo_next;
    end
  end

endmodule

### design/tefu_index_wrap.sv
// Address stages: reduces the pixel index modulo PIXELS by reciprocal multiply.
module tefu_index_wrap import tefu_pkg::*; #(
  parameter int PIXELS = PIXELS_DEF,
  parameter int ADDR_W = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  output logic                 ready,
  input  logic [PIX_IDX_W-1:0] index,
  input  pix_t                 pix,
  output logic                 out_v,
  output logic [ADDR_W-1:0]    out_addr,
  output pix_t                 out_pix,
  input  logic                 out_take
);

  localparam int C_W  = $clog2(PIXELS);
  localparam int K    = PIX_IDX_W + C_W;
  localparam int P1_W = K + PIX_IDX_W;
  localparam int PW   = $clog2(PIXELS + 1);
  localparam int P2_W = PIX_IDX_W + PW;
  localparam logic [P1_W-1:0] MUL = P1_W'((64'd1 << K) / PIXELS);

  logic                 a_v, b_v;
  logic [PIX_IDX_W-1:0] a_idx, b_idx;
  pix_t                 a_pix, b_pix;
  logic [P1_W-1:0]      a_prod;
  logic [P2_W-1:0]      b_prod;
  logic [P2_W-1:0]      rem;
  logic [P2_W-1:0]      rem_c;
  logic                 en_a, en_b, en_s1;

  assign en_s1 = !out_v || out_take;
  assign en_b  = !b_v || en_s1;
  assign en_a  = !a_v || en_b;
  assign ready = en_a;

  // quotient estimate is low by at most one, so one correction suffices
  always_comb begin
    rem   = P2_W'(b_idx) - b_prod;
    rem_c = (rem >= P2_W'(PIXELS)) ? rem - P2_W'(PIXELS) : rem;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (en_a)  a_v   <= accept;
      if (en_b)  b_v   <= a_v;
      if (en_s1) out_v <= b_v;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_idx  <= index;
      a_pix  <= pix;
      a_prod <= P1_W'(index) * MUL;
    end
    if (en_b) begin
      b_idx  <= a_idx;
      b_pix  <= a_pix;
      b_prod <= P2_W'(a_prod[K +: PIX_IDX_W]) * P2_W'(PIXELS);
    end
    if (en_s1) begin
      out_addr <= rem_c[ADDR_W-1:0];
      out_pix  <= b_pix;
    end
  end

endmodule

### design/tefu_frame_store.sv
// Frame store: accumulator memory with a clearing sweep after reset.
module tefu_frame_store import tefu_pkg::*; #(
  parameter int PIXELS = PIXELS_DEF,
  parameter int ADDR_W = 20,
  parameter int DATA_W = 72
) (
  input  logic              clk,
  input  logic              rst,
  output logic              busy,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [PIXELS];
  logic [ADDR_W-1:0] clear_addr;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [DATA_W-1:0] wd;

  // clearing sweep owns the write port until done
  always_comb begin
    we = busy || wr_en;
    wa = busy ? clear_addr : wr_addr;
    wd = busy ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      clear_addr <= '0;
    end else if (busy) begin
      clear_addr <= clear_addr + ADDR_W'(1);
      if (clear_addr == ADDR_W'(PIXELS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

### design/tefu_ema_core.sv
// EMA core: read, difference, weight multiply, accumulate and write back.
`include "temporal_ema_ycbcr_filter_unit_defines.svh"

module tefu_ema_core import tefu_pkg::*; #(
  parameter int ADDR_W        = 20,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s1_v,
  input  logic [ADDR_W-1:0]                         s1_addr,
  input  pix_t                                      s1_pix,
  output logic                                      s1_take,
  input  logic [FRACTION_BITS:0]                    weight,
  output logic                                      rd_en,
  output logic [ADDR_W-1:0]                         rd_addr,
  input  logic [3*(SAMPLE_W+FRACTION_BITS)-1:0]     rd_data,
  output logic                                      wr_en,
  output logic [ADDR_W-1:0]                         wr_addr,
  output logic [3*(SAMPLE_W+FRACTION_BITS)-1:0]     wr_data,
  tefu_res_if.source                                result
);

  localparam int ACC_W  = SAMPLE_W + FRACTION_BITS;
  localparam int EXT_W  = ACC_W + 1;
  localparam int WT_W   = FRACTION_BITS + 1;
  localparam int PROD_W = EXT_W + WT_W + 1;
  localparam int CH_Y   = 0;
  localparam int CH_CB  = 1;
  localparam int CH_CR  = 2;
  localparam logic [ACC_W-1:0] LUMA_MAX = {{SAMPLE_W{1'b1}}, {FRACTION_BITS{1'b0}}};

  logic              s2_v, s3_v, s4_v, out_v;
  logic [ADDR_W-1:0] s2_addr, s3_addr, s4_addr;
  pix_t              s2_pix;
  logic              en_s2, en_s3, en_s4, en_out, hazard;

  logic signed [EXT_W-1:0]  acc_ext  [3];
  logic signed [EXT_W-1:0]  smp_ext  [3];
  logic signed [EXT_W-1:0]  diff     [3];
  logic signed [EXT_W-1:0]  s3_acc   [3];
  logic signed [EXT_W-1:0]  s3_diff  [3];
  logic signed [PROD_W-1:0] prod     [3];
  logic signed [EXT_W-1:0]  s4_acc   [3];
  logic signed [PROD_W-1:0] s4_prod  [3];
  logic signed [PROD_W-1:0] step     [3];
  logic signed [EXT_W-1:0]  new_acc  [3];
  logic [SAMPLE_W-1:0]      out_luma, out_cb, out_cr;

  // stage enables, back to front
  assign en_out = !out_v || result.ready;
  assign en_s4  = !s4_v || en_out;
  assign en_s3  = !s3_v || en_s4;
  assign en_s2  = !s2_v || en_s3;

  // interlock: an entry still in read-modify-write is not read again
  assign hazard = (s2_v && (s2_addr == s1_addr)) ||
                  (s3_v && (s3_addr == s1_addr)) ||
                  (s4_v && (s4_addr == s1_addr));
  assign s1_take = s1_v && en_s2 && !hazard;
  assign rd_en   = s1_take;
  assign rd_addr = s1_addr;

  // difference to the sample, chroma re-centered on zero
  always_comb begin
    acc_ext[CH_Y]  = $signed({1'b0, rd_data[ACC_W-1:0]});
    acc_ext[CH_CB] = $signed({rd_data[2*ACC_W-1], rd_data[2*ACC_W-1:ACC_W]});
    acc_ext[CH_CR] = $signed({rd_data[3*ACC_W-1], rd_data[3*ACC_W-1:2*ACC_W]});
    smp_ext[CH_Y]  = $signed({1'b0, s2_pix.luma, {FRACTION_BITS{1'b0}}});
    smp_ext[CH_CB] = $signed({~s2_pix.cb[SAMPLE_W-1], ~s2_pix.cb[SAMPLE_W-1],
                              s2_pix.cb[SAMPLE_W-2:0], {FRACTION_BITS{1'b0}}});
    smp_ext[CH_CR] = $signed({~s2_pix.cr[SAMPLE_W-1], ~s2_pix.cr[SAMPLE_W-1],
                              s2_pix.cr[SAMPLE_W-2:0], {FRACTION_BITS{1'b0}}});
    for (int c = 0; c < 3; c++) begin
      diff[c] = smp_ext[c] - acc_ext[c];
    end
  end

  // weight multiply
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = s3_diff[c] * $signed({1'b0, weight});
    end
  end

  // floor of the weighted step, accumulate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      step[c]    = s4_prod[c] >>> FRACTION_BITS;
      new_acc[c] = s4_acc[c] + step[c][EXT_W-1:0];
    end
  end

  // write back as the item leaves the last stage
  assign wr_en   = s4_v && en_s4;
  assign wr_addr = s4_addr;
  assign wr_data = {new_acc[CH_CR][ACC_W-1:0], new_acc[CH_CB][ACC_W-1:0],
                    new_acc[CH_Y][ACC_W-1:0]};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (en_s2)  s2_v  <= s1_take;
      if (en_s3)  s3_v  <= s2_v;
      if (en_s4)  s4_v  <= s3_v;
      if (en_out) out_v <= s4_v;
    end
  end

  // payload; accumulators stay in sample range, so the integer part needs no clamp
  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_addr <= s1_addr;
      s2_pix  <= s1_pix;
    end
    if (en_s3) begin
      s3_addr <= s2_addr;
      s3_acc  <= acc_ext;
      s3_diff <= diff;
    end
    if (en_s4) begin
      s4_addr <= s3_addr;
      s4_acc  <= s3_acc;
      s4_prod <= prod;
    end
    if (en_out) begin
      out_luma <= new_acc[CH_Y][FRACTION_BITS +: SAMPLE_W];
      out_cb   <= {~new_acc[CH_CB][ACC_W-1], new_acc[CH_CB][FRACTION_BITS +: SAMPLE_W-1]};
      out_cr   <= {~new_acc[CH_CR][ACC_W-1], new_acc[CH_CR][FRACTION_BITS +: SAMPLE_W-1]};
    end
  end

  assign result.valid    = out_v;
  assign result.luma_out = out_luma;
  assign result.cb_out   = out_cb;
  assign result.cr_out   = out_cr;

  // no two in-flight requests share a store entry
  `TEFU_ASSERT_IMPLY(a_s2_s3_distinct, clk, rst, s2_v && s3_v, s2_addr != s3_addr, "s2/s3 same entry")
  `TEFU_ASSERT_IMPLY(a_s2_s4_distinct, clk, rst, s2_v && s4_v, s2_addr != s4_addr, "s2/s4 same entry")
  `TEFU_ASSERT_IMPLY(a_s3_s4_distinct, clk, rst, s3_v && s4_v, s3_addr != s4_addr, "s3/s4 same entry")
  // luma accumulator never leaves 0..255
  `TEFU_ASSERT_IMPLY(a_luma_range, clk, rst, wr_en, wr_data[ACC_W-1:0] <= LUMA_MAX, "luma out of range")

endmodule

### design/temporal_ema_ycbcr_filter_unit.sv
// Temporal EMA YCbCr filter: one read-modify-write frame store per pixel stream.
// A taken pixel request passes the index-wrap stages, then core stages s2, s3 and s4.
// Throughput: one pixel per cycle while results are taken; a pixel whose store entry is
// still in one of the three read-modify-write stages waits until it is written back.
// Reset: the store is swept to zero entry by entry with the input held off.
// A smoothing_factor write reloads the weight by sequential division, input held off.
module temporal_ema_ycbcr_filter_unit import tefu_pkg::*; #(
  parameter int PIXELS        = PIXELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  tefu_pix_if.sink           pixel,
  tefu_res_if.source         result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int ACC_W  = SAMPLE_W + FRACTION_BITS;
  localparam int DATA_W = 3 * ACC_W;

  logic [FACTOR_W-1:0]      smoothing_factor;
  logic                     cfg_wr;
  logic                     recip_busy;
  logic [FRACTION_BITS:0]   weight;
  logic                     store_busy;
  logic                     wrap_ready;
  logic                     accept;
  logic                     s1_v, s1_take;
  logic [ADDR_W-1:0]        s1_addr;
  pix_t                     in_pix, s1_pix;
  logic                     rd_en, wr_en;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic [DATA_W-1:0]        rd_data, wr_data;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[REG_IDX_LSB] == REG_SMOOTHING_FACTOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_factor <= FACTOR_RESET;
    end else if (cfg_wr) begin
      smoothing_factor <= pwdata[FACTOR_W-1:0];
    end
  end

  assign prdata = (paddr[REG_IDX_LSB] == REG_SMOOTHING_FACTOR) ?
                  PDATA_W'(smoothing_factor) : '0;

  // input handshake
  assign pixel.ready = wrap_ready && !store_busy && !recip_busy;
  assign accept      = pixel.valid && pixel.ready;
  assign in_pix      = '{luma: pixel.luma_in, cb: pixel.cb_in, cr: pixel.cr_in};

  tefu_recip #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_recip (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_wr),
    .factor (pwdata[FACTOR_W-1:0]),
    .busy   (recip_busy),
    .weight (weight)
  );

  tefu_index_wrap #(
    .PIXELS (PIXELS),
    .ADDR_W (ADDR_W)
  ) u_wrap (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .ready    (wrap_ready),
    .index    (pixel.pixel_index),
    .pix      (in_pix),
    .out_v    (s1_v),
    .out_addr (s1_addr),
    .out_pix  (s1_pix),
    .out_take (s1_take)
  );

  tefu_frame_store #(
    .PIXELS (PIXELS),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .busy    (store_busy),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tefu_ema_core #(
    .ADDR_W        (ADDR_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .s1_v    (s1_v),
    .s1_addr (s1_addr),
    .s1_pix  (s1_pix),
    .s1_take (s1_take),
    .weight  (weight),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .result  (result)
  );

endmodule

### tb/temporal_ema_ycbcr_filter_unit_tb.sv
// Testbench for the temporal EMA YCbCr filter: directed table plus random pixel streams.
module temporal_ema_ycbcr_filter_unit_tb import tefu_pkg::*;;

  localparam int FB            = FRACTION_BITS_DEF;
  localparam int RESET_CYCLES  = 11;
  localparam int DIRECTED_ROWS = 20;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int HOT_PIXELS    = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam longint CYCLE_LIMIT = 3 * longint'(PIXELS_DEF) + 200000;

  localparam logic [PADDR_W-1:0] FACTOR_ADDR   = PADDR_W'(REG_SMOOTHING_FACTOR) << REG_IDX_LSB;
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(1) << REG_IDX_LSB;

  // one row of the directed table; want is only meaningful when typed is set
  typedef struct packed {
    logic [FACTOR_W-1:0]  factor;
    logic [PIX_IDX_W-1:0] idx;
    pix_t                 pix;
    logic                 typed;
    pix_t                 want;
  } pixel_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_BLOCKS} stall_mode_e;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               res_ready = 1'b0;

  tefu_pix_if pixel_req ();
  tefu_res_if filtered ();

  assign filtered.ready = res_ready;

  always #1 clk = ~clk;

  temporal_ema_ycbcr_filter_unit uut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel_req),
    .result  (filtered),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Directed table: N=1 and N=0 rows pass the sample straight through
  pixel_row_t directed_rows [DIRECTED_ROWS] = '{
    '{10'd1,    20'h00000, '{8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{10'd1,    20'hFFFFF, '{8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'hFF, 8'hFF, 8'hFF}},
    '{10'd1,    20'h00000, '{8'hFF, 8'h80, 8'h80}, 1'b1, '{8'hFF, 8'h80, 8'h80}},
    '{10'd1,    20'h00000, '{8'h00, 8'hFF, 8'h00}, 1'b1, '{8'h00, 8'hFF, 8'h00}},
    '{10'd1,    20'h00001, '{8'h80, 8'h7F, 8'h81}, 1'b1, '{8'h80, 8'h7F, 8'h81}},
    '{10'd1,    20'hAAAAA, '{8'h55, 8'hAA, 8'h55}, 1'b1, '{8'h55, 8'hAA, 8'h55}},
    '{10'd1,    20'h55555, '{8'hAA, 8'h55, 8'hAA}, 1'b1, '{8'hAA, 8'h55, 8'hAA}},
    '{10'd0,    20'h00000, '{8'h11, 8'hC8, 8'h03}, 1'b1, '{8'h11, 8'hC8, 8'h03}},
    '{10'd0,    20'h00002, '{8'hFF, 8'h00, 8'hFF}, 1'b1, '{8'hFF, 8'h00, 8'hFF}},
    '{10'd1023, 20'hFFFFF, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
    '{10'd1023, 20'hFFFFF, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
    '{10'd1023, 20'h00010, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
    '{10'd2,    20'h00020, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
    '{10'd2,    20'h00020, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
    '{10'd2,    20'h00020, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
    '{10'd2,    20'h00020, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
    '{10'd1000, 20'h00003, '{8'hFF, 8'h00, 8'hFF}, 1'b0, '0},
    '{10'd1000, 20'h00003, '{8'hFF, 8'h00, 8'hFF}, 1'b0, '0},
    '{10'd3,    20'h00000, '{8'hFF, 8'hFF, 8'h00}, 1'b0, '0},
    '{10'd3,    20'h00000, '{8'hFF, 8'hFF, 8'h00}, 1'b0, '0}
  };

  // Predictor state: Q8.16 accumulators per pixel, absent entries are zero
  longint              luma_store [int];
  longint              cb_store [int];
  longint              cr_store [int];
  logic [FACTOR_W-1:0] factor_q = FACTOR_RESET;
  longint              weight_q16 = longint'(1) <<< FB;

  pix_t        pending_pixels [$];
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned settings_used = 1;
  int          burst_left = 0;
  longint      cycle_count = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int unsigned stall_tick = 0;

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch: %s expected %0d got %0d (cycle %0d)", what, want, got, cycle_count);
  endtask

  // weight = 1/N rounded to nearest in Q1.16; zero counts as one
  task automatic load_factor(logic [PDATA_W-1:0] data);
    longint n;
    factor_q = data[FACTOR_W-1:0];
    n = (factor_q == '0) ? 1 : longint'(factor_q);
    weight_q16 = ((longint'(1) <<< FB) + n / 2) / n;
    settings_used++;
  endtask

  function automatic longint ema_move(longint acc, longint sample);
    longint diff;
    diff = (sample <<< FB) - acc;
    return acc + ((diff * weight_q16) >>> FB);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(longint q);
    longint v;
    v = q >>> FB;
    if (v <= 0) return '0;
    if (v >= 255) return 8'hFF;
    return v[SAMPLE_W-1:0];
  endfunction

  // Update the stored averages of one pixel and return its filtered samples
  function automatic pix_t filter_pixel(logic [PIX_IDX_W-1:0] idx, pix_t pix);
    int     key;
    longint y_acc;
    longint b_acc;
    longint r_acc;
    pix_t   res;
    key   = int'(idx) % PIXELS_DEF;
    y_acc = luma_store.exists(key) ? luma_store[key] : 0;
    b_acc = cb_store.exists(key) ? cb_store[key] : 0;
    r_acc = cr_store.exists(key) ? cr_store[key] : 0;
    y_acc = ema_move(y_acc, longint'(pix.luma));
    b_acc = ema_move(b_acc, longint'(pix.cb) - 128);
    r_acc = ema_move(r_acc, longint'(pix.cr) - 128);
    luma_store[key] = y_acc;
    cb_store[key]   = b_acc;
    cr_store[key]   = r_acc;
    res.luma = clamp_sample(y_acc);
    res.cb   = clamp_sample(b_acc + (longint'(128) <<< FB));
    res.cr   = clamp_sample(r_acc + (longint'(128) <<< FB));
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic pix_t pick_pixel();
    pix_t p;
    p.luma = pick_sample();
    p.cb   = pick_sample();
    p.cr   = pick_sample();
    return p;
  endfunction

  // APB write: setup then access phase, then psel drops and the bus idles; caller sits on a rising edge
  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == FACTOR_ADDR)
      load_factor(data);
    @(posedge clk);
  endtask

  // APB read of the factor register, compared with the predicted value
  task automatic check_factor_reg();
    logic [PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FACTOR_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== PDATA_W'(factor_q))
      flag_mismatch("smoothing_factor readback", factor_q, got);
  endtask

  // Offer one pixel request, after a random idle gap (possibly none) when a burst has run out
  task automatic send_pixel(logic [PIX_IDX_W-1:0] idx, pix_t pix, logic typed, pix_t want);
    int   gap;
    pix_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        pixel_req.valid       <= 1'b0;
        pixel_req.pixel_index <= PIX_IDX_W'($urandom());
        pixel_req.luma_in     <= SAMPLE_W'($urandom());
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pixel_req.valid       <= 1'b1;
    pixel_req.pixel_index <= idx;
    pixel_req.luma_in     <= pix.luma;
    pixel_req.cb_in       <= pix.cb;
    pixel_req.cr_in       <= pix.cr;
    do @(posedge clk); while (!pixel_req.ready);
    predicted = filter_pixel(idx, pix);
    pending_pixels.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  // Stop offering requests until every result is back
  task automatic hold_until_drained();
    pixel_req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // Result side: compare against the oldest prediction, then pick next ready
  always @(posedge clk) begin
    pix_t want;
    if (!rst && filtered.valid && res_ready) begin
      checked_count++;
      if (pending_pixels.size() == 0) begin
        flag_mismatch("result with nothing pending, luma", 0, filtered.luma_out);
      end else begin
        want = pending_pixels.pop_front();
        if (filtered.luma_out !== want.luma) flag_mismatch("luma_out", want.luma, filtered.luma_out);
        if (filtered.cb_out !== want.cb) flag_mismatch("cb_out", want.cb, filtered.cb_out);
        if (filtered.cr_out !== want.cr) flag_mismatch("cr_out", want.cr, filtered.cr_out);
      end
    end
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(32, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:   res_ready <= 1'b1;
      STALL_COIN:   res_ready <= 1'($urandom_range(0, 1));
      STALL_SPARSE: res_ready <= (stall_tick % 4 == 0);
      STALL_BLOCKS: res_ready <= ((stall_tick / 8) % 2 == 0);
    endcase
  end

  // Watchdog; the limit covers the store clearing pass after reset
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [PIX_IDX_W-1:0] hot_idx [HOT_PIXELS];
    pix_t                 hot_color [HOT_PIXELS];
    logic [PIX_IDX_W-1:0] idx;
    logic [PIX_IDX_W-1:0] last_idx;
    logic [PDATA_W-1:0]   setting;
    pix_t                 pix;
    int                   roll;
    int                   h;
    int                   pause_at;

    pixel_req.valid       <= 1'b0;
    pixel_req.pixel_index <= '0;
    pixel_req.luma_in     <= '0;
    pixel_req.cb_in       <= '0;
    pixel_req.cr_in       <= '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_factor_reg();

    // Directed table; a factor change waits for the pipe to empty
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].factor != factor_q) begin
        hold_until_drained();
        reg_write(FACTOR_ADDR, PDATA_W'(directed_rows[r].factor));
        check_factor_reg();
      end
      send_pixel(directed_rows[r].idx, directed_rows[r].pix,
                 directed_rows[r].typed, directed_rows[r].want);
    end

    // A write to an unmapped register leaves the factor alone
    hold_until_drained();
    reg_write(UNMAPPED_ADDR, 32'h0000_03FF);
    check_factor_reg();

    // Random part: a few hot pixels fed a steady scene, plus scene cuts and noise
    hot_idx[0] = '0;
    hot_idx[1] = '1;
    for (int i = 2; i < HOT_PIXELS; i++) hot_idx[i] = PIX_IDX_W'($urandom());
    for (int i = 0; i < HOT_PIXELS; i++) hot_color[i] = pick_pixel();
    last_idx = hot_idx[0];

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       setting = 32'd1000;
        1:       setting = ($urandom() & ~32'h3FF) | 32'h3FF;
        2:       setting = 32'd2;
        3:       setting = $urandom_range(3, 999);
        4:       setting = 32'd0;
        5:       setting = $urandom_range(1, 16);
        6:       setting = 32'd1;
        default: setting = $urandom_range(1, 1000);
      endcase
      hold_until_drained();
      reg_write(FACTOR_ADDR, setting);
      check_factor_reg();
      pause_at = $urandom_range(5, PHASE_ITEMS - 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == pause_at)
          hold_until_drained();
        roll = $urandom_range(0, 99);
        h = $urandom_range(0, HOT_PIXELS - 1);
        if (roll < 60) begin
          idx = hot_idx[h];
          pix = hot_color[h];
        end else if (roll < 70) begin
          hot_color[h] = pick_pixel();
          idx = hot_idx[h];
          pix = hot_color[h];
        end else if (roll < 80) begin
          idx = last_idx;
          pix = pick_pixel();
        end else begin
          idx = PIX_IDX_W'($urandom());
          pix = pick_pixel();
        end
        last_idx = idx;
        send_pixel(idx, pix, 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Streamed %0d pixel requests under %0d smoothing settings;", sent_count,
             settings_used);
    $display("%0d filtered results compared, %0d mismatches.", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
